@@ sv/ufdq_pkg.sv @@
// ----------------------------------------------------------------------------
// ufdq_pkg
// Shared constants, codes and controller/datapath interface types for the
// urgent-front deque queue.
// ----------------------------------------------------------------------------
package ufdq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W   = 16;
    localparam int TYPE_W = 8;
    localparam int PRIO_W = 2;
    localparam int ENTRY_W = ID_W + TYPE_W + PRIO_W;

    localparam logic [PRIO_W-1:0] URGENT_LEVEL = 2'd2;

    typedef enum logic [2:0] {
        OP_ENQ    = 3'd0,
        OP_DEQ    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_COUNT  = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_FRONT,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] kind;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    latch;
        logic    enq;
        logic    rd_front;
        logic    use_front;
        logic    scan_start;
        logic    scan_next;
        logic    acc;
        logic    load;
        status_t st;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic empty;
        logic full;
        logic scan_stop;
    } stat_t;

endpackage

@@ sv/ufdq_ram.sv @@
// ----------------------------------------------------------------------------
// ufdq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ufdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ufdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ufdq_ctrl
// Command sequencer: dispatches each command and steps the entry scan.
// ----------------------------------------------------------------------------
module ufdq_ctrl
    import ufdq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_DEQ, OP_PEEK: state_next = stat.empty ? S_IDLE : S_FRONT;
                    OP_COUNT, OP_SEARCH: state_next = stat.empty ? S_IDLE : S_SCAN;
                    default: state_next = S_IDLE;
                endcase
            end
            S_FRONT:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.scan_stop)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.st = ST_OK;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                ctl.latch = start;
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_ENQ:
                    begin
                        ctl.load = 1'b1;
                        if (stat.full)
                        begin
                            ctl.st = ST_FULL;
                        end
                        else
                        begin
                            ctl.enq = 1'b1;
                        end
                    end
                    OP_DEQ, OP_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            ctl.load = 1'b1;
                            ctl.st = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_front = 1'b1;
                        end
                    end
                    OP_COUNT, OP_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            ctl.load = 1'b1;
                        end
                        else
                        begin
                            ctl.scan_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.load = 1'b1;
                    end
                endcase
            end
            S_FRONT:
            begin
                ctl.load = 1'b1;
                ctl.use_front = 1'b1;
            end
            S_SCAN:
            begin
                ctl.acc = 1'b1;
                if (stat.scan_stop)
                begin
                    ctl.load = 1'b1;
                end
                else
                begin
                    ctl.scan_next = 1'b1;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

@@ sv/ufdq_datapath.sv @@
// ----------------------------------------------------------------------------
// ufdq_datapath
// Ring storage, head and count registers, scan counter and result registers.
// ----------------------------------------------------------------------------
module ufdq_datapath
    import ufdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    output stat_t             stat,
    input  logic [2:0]        cmd,
    input  logic [ID_W-1:0]   ticket_id,
    input  logic [TYPE_W-1:0] issue_type,
    input  logic [PRIO_W-1:0] priority_level,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   out_id,
    output logic [TYPE_W-1:0] out_type,
    output logic [PRIO_W-1:0] out_priority,
    output logic [CNT_W-1:0]  match_count,
    output logic              found,
    output logic [CNT_W-1:0]  occupancy
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_W = (IDX_W+1)'(QUEUE_DEPTH);

    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [PRIO_W-1:0] prio_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] match_reg;
    logic             done_reg;

    logic [IDX_W-1:0] addr;
    logic             we;
    entry_t           wentry;
    entry_t           rentry;
    logic [ENTRY_W-1:0] rdata;

    logic             pop;
    logic             id_eq;
    logic             type_eq;
    logic [CNT_W-1:0] match_sum;
    logic [IDX_W-1:0] idx_plus;

    // position offset entries from the head, wrapped on the ring
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign rentry  = entry_t'(rdata);
    assign id_eq   = (rentry.id == id_reg);
    assign type_eq = (rentry.kind == type_reg);
    assign pop     = ctl.use_front && (op_reg == OP_DEQ);
    assign idx_plus = idx_reg + 1'b1;
    assign match_sum = match_reg + CNT_W'(ctl.acc && type_eq);

    assign stat.op        = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= DEPTH_C);
    assign stat.scan_stop = ({1'b0, idx_reg} == (count_reg - 1'b1))
                          || ((op_reg == OP_SEARCH) && id_eq);

    // ring address for the current action
    always_comb
    begin
        we = ctl.enq;
        wentry.id = id_reg;
        wentry.kind = type_reg;
        wentry.prio = prio_reg;
        addr = head_reg;
        if (ctl.enq)
        begin
            if (prio_reg == URGENT_LEVEL)
            begin
                addr = head_next;
            end
            else
            begin
                addr = ring_add(head_reg, count_reg[IDX_W-1:0]);
            end
        end
        else if (ctl.scan_next)
        begin
            addr = ring_add(head_reg, idx_plus);
        end
        else if (ctl.rd_front)
        begin
            // front entry is read for dequeue and peek
            addr = head_reg;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.enq)
        begin
            count_next = count_reg + 1'b1;
            if (prio_reg == URGENT_LEVEL)
            begin
                head_next = (head_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;
            end
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = ring_add(head_reg, IDX_W'(1));
        end
    end

    ufdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wentry),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= ctl.load;
        end
    end

    // operand capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            op_reg    <= op_t'(cmd);
            id_reg    <= ticket_id;
            type_reg  <= issue_type;
            prio_reg  <= priority_level;
            match_reg <= '0;
        end
        if (ctl.scan_start)
        begin
            idx_reg   <= '0;
            match_reg <= '0;
        end
        else if (ctl.scan_next)
        begin
            idx_reg   <= idx_plus;
            match_reg <= match_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            status       <= ctl.st;
            out_id       <= ctl.use_front ? rentry.id : '0;
            out_type     <= ctl.use_front ? rentry.kind : '0;
            out_priority <= ctl.use_front ? rentry.prio : '0;
            match_count  <= (op_reg == OP_COUNT) ? match_sum : '0;
            found        <= ctl.acc && (op_reg == OP_SEARCH) && id_eq;
            occupancy    <= count_next;
        end
    end

    assign done = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.enq |-> (count_reg < DEPTH_C))
        else $error("write into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("removal from an empty queue");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (occupancy == count_reg))
        else $error("reported occupancy differs from held count");

endmodule

@@ sv/urgent_front_deque_queue.sv @@
// ----------------------------------------------------------------------------
// urgent_front_deque_queue
// Bounded deque: urgent entries go in at the front, others at the back.
// ----------------------------------------------------------------------------
// usage
//   command channel: drive cmd, ticket_id, issue_type and priority_level with
//   start high; the transfer happens on a clock edge where busy is low.
//   result channel: done is high for one cycle with status, out_id, out_type,
//   out_priority, match_count, found and occupancy; the receiver must take it
//   then, it cannot stall the block.
//   steps from the command transfer to done, in order:
//     enqueue, unused codes, any command on an empty queue: dispatch only
//     dequeue and peek on a held entry: dispatch, then the front read
//     count: dispatch, then a scan over every held entry; search: dispatch,
//     then a scan that stops at the first hit or at the last held entry
//   the walk over held entries reads the single-port entry store one entry
//   a cycle; busy falls in the cycle done is raised, so the next command can
//   transfer while the previous result is shown.
//   reset clears the head position and the entry count; the entry store is
//   not cleared, only held entries are ever read.
// ----------------------------------------------------------------------------
module urgent_front_deque_queue
    import ufdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic [ID_W-1:0]   ticket_id,
    input  logic [TYPE_W-1:0] issue_type,
    input  logic [PRIO_W-1:0] priority_level,
    output logic              done,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   out_id,
    output logic [TYPE_W-1:0] out_type,
    output logic [PRIO_W-1:0] out_priority,
    output logic [CNT_W-1:0]  match_count,
    output logic              found,
    output logic [CNT_W-1:0]  occupancy
);

    ctl_t  ctl;
    stat_t stat;

    ufdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    ufdq_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .ticket_id      (ticket_id),
        .issue_type     (issue_type),
        .priority_level (priority_level),
        .done           (done),
        .status         (status),
        .out_id         (out_id),
        .out_type       (out_type),
        .out_priority   (out_priority),
        .match_count    (match_count),
        .found          (found),
        .occupancy      (occupancy)
    );

endmodule
